@@ rtl/sdtt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted deadline timer table: shared package
// Command and result codes, slot states and the operand types of the shared
// add and compare unit.
// ----------------------------------------------------------------------------
package sdtt_pkg;

   localparam int CMD_W   = 3;
   localparam int FSLOT_W = 4;
   localparam int TIME_W  = 32;
   localparam int DEST_W  = 4;
   localparam int TAG_W   = 8;
   localparam int KIND_W  = 3;

   // Commands
   localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FREE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_BIND  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ARM   = 3'd4;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_DONE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NONE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EXPIRY = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REJECT = 3'd4;

   // Slot states
   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   localparam logic [TIME_W-1:0] NO_DEADLINE = 32'hffff_ffff;
   localparam logic [4:0]        MAX_RESULTS = 5'd16;

   typedef struct packed {
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
   } alu_in_type;

   typedef struct packed {
      logic [TIME_W-1:0] sum;
      logic              le;
   } alu_out_type;

endpackage

@@ rtl/sdtt_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted deadline timer table: channel interfaces
// Valid/ready channels for the request and the result streams.
// ----------------------------------------------------------------------------
interface sdtt_req_if import sdtt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [FSLOT_W-1:0] slot;
   logic [TIME_W-1:0]  delay;
   logic [DEST_W-1:0]  dest;
   logic [TAG_W-1:0]   tag;

   modport source (output valid, cmd, slot, delay, dest, tag, input ready);
   modport sink   (input valid, cmd, slot, delay, dest, tag, output ready);
endinterface

interface sdtt_rsp_if import sdtt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [FSLOT_W-1:0] slot_out;
   logic [DEST_W-1:0]  dest_out;
   logic [TAG_W-1:0]   tag_out;
   logic               last;

   modport source (output valid, kind, slot_out, dest_out, tag_out, last, input ready);
   modport sink   (input valid, kind, slot_out, dest_out, tag_out, last, output ready);
endinterface

@@ rtl/sdtt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted deadline timer table: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/sdtt_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted deadline timer table: shared arithmetic unit
// One 32-bit adder and one unsigned less-or-equal compare, shared by the
// time update, the deadline computation and every deadline compare.
// ----------------------------------------------------------------------------
module sdtt_alu import sdtt_pkg::*; (
   input  alu_in_type  operands,
   output alu_out_type result
);

   always_comb begin
      result.sum = operands.a + operands.b;
      result.le  = (operands.a <= operands.b);
   end

endmodule

@@ rtl/sorted_deadline_timer_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted deadline timer table
// Pool of one-shot timers with a deadline-ordered run list, driven by a
// small sequencer around one shared add/compare unit and four RAMs.
//
//   Channel   Direction  Handshake            Payload
//   req_ch    in         valid/ready          cmd, slot, delay, dest, tag
//   rsp_ch    out        valid/ready          kind, slot_out, dest_out, tag_out, last
//
// A request is taken only in the idle state; each one walks the run list or
// the slot states through the single read port of a RAM, one entry at a time.
// Bind writes the bind RAM and replies. A tick that expires slots reports
// each expiry, then moves the remaining entries to the front of the list and
// reloads the head deadline. Allocate scans the slot states in order; free
// and arm search the run list and move the entries behind the point of change.
// Reset is synchronous and leaves all slots free; no clearing pass runs.
// A stalled result holds the sequencer only when it has a further result.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_table_core import sdtt_pkg::*; #(
   parameter int SLOTS = 16
) (
   input logic          clock,
   input logic          reset,
   sdtt_req_if.sink     req_ch,
   sdtt_rsp_if.source   rsp_ch
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
   localparam logic [CW-1:0] LAST_C  = CW'(SLOTS - 1);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DECODE   = 5'd1;
   localparam logic [4:0] S_REPLY    = 5'd2;
   localparam logic [4:0] S_TICK_ADD = 5'd3;
   localparam logic [4:0] S_TICK_CMP = 5'd4;
   localparam logic [4:0] S_EXP_RD0  = 5'd5;
   localparam logic [4:0] S_EXP_RD1  = 5'd6;
   localparam logic [4:0] S_EXP_CHK  = 5'd7;
   localparam logic [4:0] S_EXP_END  = 5'd8;
   localparam logic [4:0] S_SH_RD    = 5'd9;
   localparam logic [4:0] S_SH_WR    = 5'd10;
   localparam logic [4:0] S_HEAD0    = 5'd11;
   localparam logic [4:0] S_HEAD1    = 5'd12;
   localparam logic [4:0] S_HEAD2    = 5'd13;
   localparam logic [4:0] S_AL_RD    = 5'd14;
   localparam logic [4:0] S_AL_CHK   = 5'd15;
   localparam logic [4:0] S_FR_CHK   = 5'd16;
   localparam logic [4:0] S_FS_RD    = 5'd17;
   localparam logic [4:0] S_FS_CHK   = 5'd18;
   localparam logic [4:0] S_AR_CHK   = 5'd19;
   localparam logic [4:0] S_AI_RD    = 5'd20;
   localparam logic [4:0] S_AI_RD2   = 5'd21;
   localparam logic [4:0] S_AI_CHK   = 5'd22;
   localparam logic [4:0] S_SU_RD    = 5'd23;
   localparam logic [4:0] S_SU_WR    = 5'd24;

   // Sequencer and request registers
   logic [4:0]         state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [FSLOT_W-1:0] slot_ff, slot_in;
   logic [TIME_W-1:0]  delay_ff, delay_in;
   logic [DEST_W-1:0]  dest_ff, dest_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;

   // Timer state
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  next_dl_ff, next_dl_in;
   logic [CW-1:0]      active_ff, active_in;
   logic [SLOTS-1:0]   st_vld_ff, st_vld_in;
   logic [SW-1:0]      st_raddr_ff, st_raddr_in;

   // Walk registers
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      src_ff, src_in;
   logic [CW-1:0]      dst_ff, dst_in;
   logic [CW-1:0]      lim_ff, lim_in;
   logic [4:0]         rcnt_ff, rcnt_in;
   logic [TIME_W-1:0]  dl_ff, dl_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [FSLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [SW-1:0]      cur_slot_ff, cur_slot_in;
   logic               pend_v_ff, pend_v_in;
   logic [SW-1:0]      pend_slot_ff, pend_slot_in;
   logic [DEST_W-1:0]  pend_dest_ff, pend_dest_in;
   logic [TAG_W-1:0]   pend_tag_ff, pend_tag_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [FSLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [DEST_W-1:0]  rsp_dest_ff, rsp_dest_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               emit;
   logic [KIND_W-1:0]  emit_kind;
   logic [FSLOT_W-1:0] emit_slot;
   logic [DEST_W-1:0]  emit_dest;
   logic [TAG_W-1:0]   emit_tag;
   logic               emit_last;
   logic               out_free;

   // RAM ports
   logic                      ord_we, ord_re;
   logic [SW-1:0]             ord_waddr, ord_raddr, ord_wdata, ord_rdata;
   logic                      dlm_we, dlm_re;
   logic [SW-1:0]             dlm_waddr, dlm_raddr;
   logic [TIME_W-1:0]         dlm_wdata, dlm_rdata;
   logic                      dt_we, dt_re;
   logic [SW-1:0]             dt_waddr, dt_raddr;
   logic [DEST_W+TAG_W-1:0]   dt_wdata, dt_rdata;
   logic                      st_we, st_re;
   logic [SW-1:0]             st_waddr, st_raddr;
   logic [1:0]                st_wdata, st_rdata;

   alu_in_type   alu_op;
   alu_out_type  alu_res;

   logic [1:0]    slot_cur;
   logic [SW-1:0] slot_sw;

   sdtt_alu u_alu (
      .operands (alu_op),
      .result   (alu_res)
   );

   sdtt_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_order_ram (
      .clock (clock), .we (ord_we), .waddr (ord_waddr), .wdata (ord_wdata),
      .re (ord_re), .raddr (ord_raddr), .rdata (ord_rdata)
   );

   sdtt_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_deadline_ram (
      .clock (clock), .we (dlm_we), .waddr (dlm_waddr), .wdata (dlm_wdata),
      .re (dlm_re), .raddr (dlm_raddr), .rdata (dlm_rdata)
   );

   sdtt_ram #(.WIDTH(DEST_W + TAG_W), .DEPTH(SLOTS)) u_bind_ram (
      .clock (clock), .we (dt_we), .waddr (dt_waddr), .wdata (dt_wdata),
      .re (dt_re), .raddr (dt_raddr), .rdata (dt_rdata)
   );

   sdtt_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_state_ram (
      .clock (clock), .we (st_we), .waddr (st_waddr), .wdata (st_wdata),
      .re (st_re), .raddr (st_raddr), .rdata (st_rdata)
   );

   // A state entry never written since reset reads as free.
   assign slot_cur = st_vld_ff[st_raddr_ff] ? st_rdata : ST_FREE;
   assign slot_sw  = SW'(slot_ff);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready    = (state_ff == S_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.kind     = rsp_kind_ff;
   assign rsp_ch.slot_out = rsp_slot_ff;
   assign rsp_ch.dest_out = rsp_dest_ff;
   assign rsp_ch.tag_out  = rsp_tag_ff;
   assign rsp_ch.last     = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      delay_in     = delay_ff;
      dest_in      = dest_ff;
      tag_in       = tag_ff;
      now_in       = now_ff;
      next_dl_in   = next_dl_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      lim_in       = lim_ff;
      rcnt_in      = rcnt_ff;
      dl_in        = dl_ff;
      kind_in      = kind_ff;
      res_slot_in  = res_slot_ff;
      cur_slot_in  = cur_slot_ff;
      pend_v_in    = pend_v_ff;
      pend_slot_in = pend_slot_ff;
      pend_dest_in = pend_dest_ff;
      pend_tag_in  = pend_tag_ff;

      emit      = 1'b0;
      emit_kind = KIND_DONE;
      emit_slot = '0;
      emit_dest = '0;
      emit_tag  = '0;
      emit_last = 1'b1;

      ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0;
      ord_re = 1'b0; ord_raddr = '0;
      dlm_we = 1'b0; dlm_waddr = slot_sw; dlm_wdata = alu_res.sum;
      dlm_re = 1'b0; dlm_raddr = ord_rdata;
      dt_we  = 1'b0; dt_waddr = slot_sw; dt_wdata = {dest_ff, tag_ff};
      dt_re  = 1'b0; dt_raddr = ord_rdata;
      st_we  = 1'b0; st_waddr = '0; st_wdata = ST_FREE;
      st_re  = 1'b0; st_raddr = slot_sw;

      alu_op.a = '0;
      alu_op.b = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = req_ch.cmd;
               slot_in  = req_ch.slot;
               delay_in = req_ch.delay;
               dest_in  = req_ch.dest;
               tag_in   = req_ch.tag;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            kind_in     = KIND_DONE;
            res_slot_in = '0;
            priority if (cmd_ff == CMD_TICK) begin
               state_in = S_TICK_ADD;
            end else if (cmd_ff == CMD_ALLOC) begin
               idx_in   = '0;
               state_in = S_AL_RD;
            end else if (cmd_ff > CMD_ARM || int'(slot_ff) >= SLOTS) begin
               kind_in  = KIND_REJECT;
               state_in = S_REPLY;
            end else if (cmd_ff == CMD_BIND) begin
               dt_we    = 1'b1;
               state_in = S_REPLY;
            end else begin
               st_re    = 1'b1;
               state_in = (cmd_ff == CMD_FREE) ? S_FR_CHK : S_AR_CHK;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = kind_ff;
               emit_slot = res_slot_ff;
               state_in  = S_IDLE;
            end
         end
         S_TICK_ADD: begin
            alu_op.a = now_ff;
            alu_op.b = 32'd1;
            now_in   = alu_res.sum;
            state_in = S_TICK_CMP;
         end
         S_TICK_CMP: begin
            alu_op.a = next_dl_ff;
            alu_op.b = now_ff;
            if (alu_res.le) begin
               idx_in    = '0;
               rcnt_in   = '0;
               pend_v_in = 1'b0;
               state_in  = S_EXP_RD0;
            end else begin
               state_in = S_REPLY;
            end
         end
         S_EXP_RD0: begin
            if (idx_ff < active_ff && rcnt_ff != MAX_RESULTS) begin
               ord_re    = 1'b1;
               ord_raddr = idx_ff[SW-1:0];
               state_in  = S_EXP_RD1;
            end else begin
               state_in = S_EXP_END;
            end
         end
         S_EXP_RD1: begin
            cur_slot_in = ord_rdata;
            dlm_re      = 1'b1;
            dt_re       = 1'b1;
            state_in    = S_EXP_CHK;
         end
         S_EXP_CHK: begin
            alu_op.a = dlm_rdata;
            alu_op.b = now_ff;
            if (alu_res.le) begin
               // The previous expiry goes out only now that we know it is not the last.
               if (!pend_v_ff || out_free) begin
                  if (pend_v_ff) begin
                     emit      = 1'b1;
                     emit_kind = KIND_EXPIRY;
                     emit_slot = FSLOT_W'(pend_slot_ff);
                     emit_dest = pend_dest_ff;
                     emit_tag  = pend_tag_ff;
                     emit_last = 1'b0;
                  end
                  pend_v_in    = 1'b1;
                  pend_slot_in = cur_slot_ff;
                  pend_dest_in = dt_rdata[DEST_W+TAG_W-1:TAG_W];
                  pend_tag_in  = dt_rdata[TAG_W-1:0];
                  st_we        = 1'b1;
                  st_waddr     = cur_slot_ff;
                  st_wdata     = ST_ALLOC;
                  idx_in       = idx_ff + CW'(1);
                  rcnt_in      = rcnt_ff + 5'd1;
                  state_in     = S_EXP_RD0;
               end
            end else begin
               state_in = S_EXP_END;
            end
         end
         S_EXP_END: begin
            if (pend_v_ff) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_kind = KIND_EXPIRY;
                  emit_slot = FSLOT_W'(pend_slot_ff);
                  emit_dest = pend_dest_ff;
                  emit_tag  = pend_tag_ff;
                  emit_last = 1'b1;
                  pend_v_in = 1'b0;
                  src_in    = idx_ff;
                  dst_in    = '0;
                  lim_in    = active_ff;
                  active_in = active_ff - idx_ff;
                  state_in  = S_SH_RD;
               end
            end else begin
               state_in = S_REPLY;
            end
         end
         S_SH_RD: begin
            if (src_ff < lim_ff) begin
               ord_re    = 1'b1;
               ord_raddr = src_ff[SW-1:0];
               state_in  = S_SH_WR;
            end else begin
               state_in = S_HEAD0;
            end
         end
         S_SH_WR: begin
            ord_we    = 1'b1;
            ord_waddr = dst_ff[SW-1:0];
            ord_wdata = ord_rdata;
            src_in    = src_ff + CW'(1);
            dst_in    = dst_ff + CW'(1);
            state_in  = S_SH_RD;
         end
         S_HEAD0: begin
            if (active_ff == '0) begin
               next_dl_in = NO_DEADLINE;
               state_in   = (cmd_ff == CMD_TICK) ? S_IDLE : S_REPLY;
            end else begin
               ord_re    = 1'b1;
               ord_raddr = '0;
               state_in  = S_HEAD1;
            end
         end
         S_HEAD1: begin
            dlm_re   = 1'b1;
            state_in = S_HEAD2;
         end
         S_HEAD2: begin
            next_dl_in = dlm_rdata;
            state_in   = (cmd_ff == CMD_TICK) ? S_IDLE : S_REPLY;
         end
         S_AL_RD: begin
            st_re    = 1'b1;
            st_raddr = idx_ff[SW-1:0];
            state_in = S_AL_CHK;
         end
         S_AL_CHK: begin
            priority if (slot_cur == ST_FREE) begin
               st_we       = 1'b1;
               st_waddr    = idx_ff[SW-1:0];
               st_wdata    = ST_ALLOC;
               kind_in     = KIND_ALLOC;
               res_slot_in = FSLOT_W'(idx_ff);
               state_in    = S_REPLY;
            end else if (idx_ff == LAST_C) begin
               kind_in  = KIND_NONE;
               state_in = S_REPLY;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_AL_RD;
            end
         end
         S_FR_CHK: begin
            st_we    = 1'b1;
            st_waddr = slot_sw;
            st_wdata = ST_FREE;
            if (slot_cur == ST_RUN) begin
               idx_in   = '0;
               state_in = S_FS_RD;
            end else begin
               state_in = S_REPLY;
            end
         end
         S_FS_RD: begin
            if (idx_ff < active_ff) begin
               ord_re    = 1'b1;
               ord_raddr = idx_ff[SW-1:0];
               state_in  = S_FS_CHK;
            end else begin
               state_in = S_HEAD0;
            end
         end
         S_FS_CHK: begin
            if (ord_rdata == slot_sw) begin
               src_in    = idx_ff + CW'(1);
               dst_in    = idx_ff;
               lim_in    = active_ff;
               active_in = active_ff - CW'(1);
               state_in  = S_SH_RD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FS_RD;
            end
         end
         S_AR_CHK: begin
            if (slot_cur != ST_ALLOC || active_ff >= SLOTS_C) begin
               kind_in  = KIND_REJECT;
               state_in = S_REPLY;
            end else begin
               alu_op.a = delay_ff;
               alu_op.b = now_ff;
               dl_in    = alu_res.sum;
               dlm_we   = 1'b1;
               st_we    = 1'b1;
               st_waddr = slot_sw;
               st_wdata = ST_RUN;
               idx_in   = '0;
               state_in = S_AI_RD;
            end
         end
         S_AI_RD: begin
            if (idx_ff < active_ff) begin
               ord_re    = 1'b1;
               ord_raddr = idx_ff[SW-1:0];
               state_in  = S_AI_RD2;
            end else begin
               src_in   = active_ff;
               state_in = S_SU_RD;
            end
         end
         S_AI_RD2: begin
            dlm_re   = 1'b1;
            state_in = S_AI_CHK;
         end
         S_AI_CHK: begin
            // Insert ahead of the first entry whose deadline is not earlier.
            alu_op.a = dl_ff;
            alu_op.b = dlm_rdata;
            if (alu_res.le) begin
               src_in   = active_ff;
               state_in = S_SU_RD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_AI_RD;
            end
         end
         S_SU_RD: begin
            if (src_ff > idx_ff) begin
               ord_re    = 1'b1;
               ord_raddr = SW'(src_ff - CW'(1));
               state_in  = S_SU_WR;
            end else begin
               ord_we    = 1'b1;
               ord_waddr = idx_ff[SW-1:0];
               ord_wdata = slot_sw;
               active_in = active_ff + CW'(1);
               state_in  = S_HEAD0;
            end
         end
         S_SU_WR: begin
            ord_we    = 1'b1;
            ord_waddr = src_ff[SW-1:0];
            ord_wdata = ord_rdata;
            src_in    = src_ff - CW'(1);
            state_in  = S_SU_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      st_raddr_in = st_re ? st_raddr : st_raddr_ff;
      st_vld_in   = st_vld_ff;
      if (st_we) begin
         st_vld_in[st_waddr] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_dest_in  = rsp_dest_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_slot_in  = emit_slot;
         rsp_dest_in  = emit_dest;
         rsp_tag_in   = emit_tag;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= '0;
         next_dl_ff   <= NO_DEADLINE;
         active_ff    <= '0;
         st_vld_ff    <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         next_dl_ff   <= next_dl_in;
         active_ff    <= active_in;
         st_vld_ff    <= st_vld_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      slot_ff      <= slot_in;
      delay_ff     <= delay_in;
      dest_ff      <= dest_in;
      tag_ff       <= tag_in;
      st_raddr_ff  <= st_raddr_in;
      idx_ff       <= idx_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      lim_ff       <= lim_in;
      rcnt_ff      <= rcnt_in;
      dl_ff        <= dl_in;
      kind_ff      <= kind_in;
      res_slot_ff  <= res_slot_in;
      cur_slot_ff  <= cur_slot_in;
      pend_slot_ff <= pend_slot_in;
      pend_dest_ff <= pend_dest_in;
      pend_tag_ff  <= pend_tag_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_dest_ff  <= rsp_dest_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Once a request is taken, no other is taken until its work is done.
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while another is in progress");

   // Only expiry results can be followed by more results of the same request.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.last) |-> (rsp_ch.kind == KIND_EXPIRY))
      else $error("result without last flag is not an expiry");

   // An empty run list always leaves the head deadline at its empty mark.
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && active_ff == '0) |-> (next_dl_ff == NO_DEADLINE))
      else $error("empty run list with a live head deadline");

   a_active_range: assert property (@(posedge clock) disable iff (reset)
      active_ff <= SLOTS_C)
      else $error("run list count beyond pool size");

   // The compacting copy never writes ahead of where it reads.
   a_copy_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_WR) |-> (dst_ff < src_ff))
      else $error("list copy destination not below source");

endmodule
